### hdl/resource_grant_table_defines.svh
// Assertion macros used by the grant table controller
`ifndef RESOURCE_GRANT_TABLE_DEFINES_SVH
`define RESOURCE_GRANT_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, held off during reset
`define RGT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, held off during reset
`define RGT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rgt_pkg.sv
// Constants, codes, payload and control types of the resource grant table
package rgt_pkg;

  // Table geometry
  localparam int MAX_PROCS = 16;
  localparam int MAX_RES   = 4;
  localparam int UNIT_BITS = 8;

  // Fixed field widths
  localparam int PROC_W  = 4;
  localparam int RES_W   = 2;
  localparam int FIELD_W = 8;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;
  localparam int CFG_W   = 3;
  localparam int CRED_N  = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

  // Derived widths
  localparam int DEPTH      = MAX_PROCS * MAX_RES;
  localparam int ROW_W      = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W      = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int CNT_W      = $clog2(MAX_RES + 1);
  localparam int PROC_STEPS = (1 << PROC_W) / MAX_PROCS;

  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST   = 2'd0,
    CMD_RELEASE   = 2'd1,
    CMD_LOAD_NEED = 2'd2,
    CMD_LOAD_FREE = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_GRANTED      = 3'd0,
    ST_UNSAFE       = 3'd1,
    ST_RELEASED     = 3'd2,
    ST_NOT_FINISHED = 3'd3,
    ST_LOADED       = 3'd4
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [PROC_W-1:0]  process;
    logic [RES_W-1:0]   resource;
    logic [FIELD_W-1:0] amount;
    logic [FIELD_W-1:0] credit_0;
    logic [FIELD_W-1:0] credit_1;
    logic [FIELD_W-1:0] credit_2;
    logic [FIELD_W-1:0] credit_3;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FIELD_W-1:0] granted_0;
    logic [FIELD_W-1:0] granted_1;
    logic [FIELD_W-1:0] granted_2;
    logic [FIELD_W-1:0] granted_3;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             latch;
    logic             do_load;
    logic             rd;
    logic             chk;
    logic             upd;
    logic             fin;
    logic [IDX_W-1:0] idx;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_e             cmd;
    logic [CNT_W-1:0] n_act;
    logic             fail;
  } sts_t;

  // Fold a process number onto the table rows by repeated subtraction
  function automatic logic [ROW_W-1:0] row_of(logic [PROC_W-1:0] p);
    logic [PROC_W:0] v;
    v = {1'b0, p};
    for (int k = 0; k < PROC_STEPS; k++) begin
      if (int'(v) >= MAX_PROCS) begin
        v = v - (PROC_W + 1)'(MAX_PROCS);
      end
    end
    return ROW_W'(v);
  endfunction

endpackage

### hdl/rgt_chan_if.sv
// Valid/ready channel interfaces: request words, response words, configuration
interface rgt_req_if;
  logic          valid;
  logic          ready;
  rgt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rgt_rsp_if;
  logic          valid;
  logic          ready;
  rgt_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rgt_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rgt_pkg::CFG_W-1:0]  resource_count;
  modport source (output valid, output resource_count, input ready);
  modport sink   (input valid, input resource_count, output ready);
endinterface

### hdl/resource_grant_table.sv
// Top level of the resource grant table: controller, datapath and channel ports
//
//  Port    Role   Word
//  req_i   sink   command, process, resource, amount, credit_0..credit_3
//  rsp_o   source status, granted_0..granted_3
//  cfg_i   sink   resource_count (always ready)
//
//  One word at a time. Request or release: a check pass over the n active types
//  (a read, then a check, per type through the single table read port), then an
//  update pass per type through the single write port; a refused word skips the
//  update pass. Loads, and words with no active types, go from dispatch straight to
//  finish with no passes. Reset clears the tables through per-entry valid bits,
//  with no clearing pass. A waiting response holds; the next word is taken
//  meanwhile and stalls only at its finish until the response is taken.
module resource_grant_table (
  input  logic   clk_i,
  input  logic   rst_ni,
  rgt_req_if.sink   req_i,
  rgt_rsp_if.source rsp_o,
  rgt_cfg_if.sink   cfg_i
);

  rgt_pkg::ctl_t ctl;
  rgt_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  rgt_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  rgt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .req_data_i  (req_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.resource_count),
    .rsp_data_o  (rsp_o.data)
  );

endmodule

### hdl/rgt_controller.sv
// Sequencer of the grant table: dispatch, check pass, update pass, result hand-off
`include "resource_grant_table_defines.svh"

module rgt_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rgt_pkg::sts_t sts_i,
  output rgt_pkg::ctl_t ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_RD,
    S_CHK,
    S_UPD,
    S_FIN
  } state_e;

  state_e                    state_q;
  logic [rgt_pkg::IDX_W-1:0] idx_q;
  logic                      out_valid_q;
  logic                      last;
  logic                      is_load;

  // Last active type reached
  assign last = (rgt_pkg::CNT_W'(idx_q) + rgt_pkg::CNT_W'(1)) == sts_i.n_act;
  assign is_load = (sts_i.cmd == rgt_pkg::CMD_LOAD_NEED) ||
                   (sts_i.cmd == rgt_pkg::CMD_LOAD_FREE);

  // Decode commands from state
  always_comb begin
    ctl_o         = '0;
    ctl_o.latch   = (state_q == S_IDLE) && in_valid_i;
    ctl_o.do_load = (state_q == S_DISP) && is_load;
    ctl_o.rd      = (state_q == S_RD);
    ctl_o.chk     = (state_q == S_CHK);
    ctl_o.upd     = (state_q == S_UPD) && !sts_i.fail;
    ctl_o.fin     = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
    ctl_o.idx     = idx_q;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Advance state, type counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_o.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DISP;
        end
        S_DISP: begin
          idx_q <= '0;
          if (is_load || (sts_i.n_act == '0)) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (last) begin
            idx_q   <= '0;
            state_q <= S_UPD;
          end else begin
            idx_q   <= idx_q + rgt_pkg::IDX_W'(1);
            state_q <= S_RD;
          end
        end
        S_UPD: begin
          if (sts_i.fail || last) begin
            idx_q   <= '0;
            state_q <= S_FIN;
          end else begin
            idx_q <= idx_q + rgt_pkg::IDX_W'(1);
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `RGT_ASSERT_NEXT(a_rd_then_chk, state_q == S_RD, state_q == S_CHK, "read not followed by check")
  `RGT_ASSERT_NEXT(a_fin_valid, ctl_o.fin, out_valid_q, "result not raised after finish")
  `RGT_ASSERT_NOW(a_disp_after_accept, state_q == S_DISP, $past(in_valid_i && in_ready_o), "dispatch without accepted word")

endmodule

### hdl/rgt_datapath.sv
// Grant table datapath: need/held memories, free counts, word and result registers
module rgt_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rgt_pkg::ctl_t              ctl_i,
  output rgt_pkg::sts_t              sts_o,
  input  rgt_pkg::req_t              req_data_i,
  input  logic                       cfg_valid_i,
  input  logic [rgt_pkg::CFG_W-1:0]  cfg_data_i,
  output rgt_pkg::rsp_t              rsp_data_o
);

  localparam int UB = rgt_pkg::UNIT_BITS;
  localparam int NR = rgt_pkg::MAX_RES;

  // Word registers
  rgt_pkg::cmd_e               cmd_q;
  logic [rgt_pkg::ROW_W-1:0]   row_q;
  logic [rgt_pkg::RES_W-1:0]   res_q;
  logic [UB-1:0]               amount_q;
  logic [UB-1:0]               credit_q [NR];

  // Per-item working state
  logic                        fail_q;
  logic [UB-1:0]               held_c_q [NR];
  logic [UB-1:0]               rem_c_q  [NR];
  logic [UB-1:0]               gnt_w_q  [NR];

  // Architectural state
  logic [UB-1:0]               free_q   [NR];
  logic [rgt_pkg::CFG_W-1:0]   count_q;
  logic [UB-1:0]               need_mem [rgt_pkg::DEPTH];
  logic [UB-1:0]               held_mem [rgt_pkg::DEPTH];
  logic [rgt_pkg::DEPTH-1:0]   need_vld_q;
  logic [rgt_pkg::DEPTH-1:0]   held_vld_q;
  logic [UB-1:0]               need_rd_q;
  logic [UB-1:0]               held_rd_q;
  logic                        need_rv_q;
  logic                        held_rv_q;

  // Result registers
  rgt_pkg::status_e            rstat_q;
  logic [UB-1:0]               rgnt_q   [rgt_pkg::CRED_N];

  logic [rgt_pkg::FIELD_W-1:0] cred_in  [rgt_pkg::CRED_N];
  logic [rgt_pkg::CNT_W-1:0]   n_act;
  logic [rgt_pkg::ADDR_W-1:0]  rd_addr;
  logic [rgt_pkg::ADDR_W-1:0]  ld_addr;
  logic [rgt_pkg::IDX_W-1:0]   res_idx;
  logic                        res_ok;
  logic [UB-1:0]               nd;
  logic [UB-1:0]               hd;
  logic [UB-1:0]               rem;
  logic                        fail_now;
  logic [UB-1:0]               grant_g;
  logic [UB:0]                 sum;
  logic [UB-1:0]               free_sat;
  logic                        grant_ok;
  rgt_pkg::status_e            stat_d;

  assign cred_in[0] = req_data_i.credit_0;
  assign cred_in[1] = req_data_i.credit_1;
  assign cred_in[2] = req_data_i.credit_2;
  assign cred_in[3] = req_data_i.credit_3;

  // Cap active types at the table width
  assign n_act = (int'(count_q) > NR) ? rgt_pkg::CNT_W'(NR) : rgt_pkg::CNT_W'(count_q);

  // Table addresses: row base plus type
  assign rd_addr = rgt_pkg::ADDR_W'(int'(row_q) * NR + int'(ctl_i.idx));
  assign ld_addr = rgt_pkg::ADDR_W'(int'(row_q) * NR + int'(res_q));
  assign res_ok  = int'(res_q) < NR;
  assign res_idx = rgt_pkg::IDX_W'(res_q);

  // Check step: entries never written read as zero
  assign nd  = need_rv_q ? need_rd_q : '0;
  assign hd  = held_rv_q ? held_rd_q : '0;
  assign rem = (nd > hd) ? (nd - hd) : '0;
  assign fail_now = (cmd_q == rgt_pkg::CMD_REQUEST) ? (rem > free_q[ctl_i.idx]) : (nd != hd);

  // Update step: grant the smaller of credit and remaining need, saturate on return
  assign grant_g  = (credit_q[ctl_i.idx] < rem_c_q[ctl_i.idx]) ?
                    credit_q[ctl_i.idx] : rem_c_q[ctl_i.idx];
  assign sum      = {1'b0, free_q[ctl_i.idx]} + {1'b0, held_c_q[ctl_i.idx]};
  assign free_sat = sum[UB] ? '1 : sum[UB-1:0];

  // Result code
  always_comb begin
    unique case (cmd_q)
      rgt_pkg::CMD_REQUEST:   stat_d = fail_q ? rgt_pkg::ST_UNSAFE : rgt_pkg::ST_GRANTED;
      rgt_pkg::CMD_RELEASE:   stat_d = fail_q ? rgt_pkg::ST_NOT_FINISHED : rgt_pkg::ST_RELEASED;
      rgt_pkg::CMD_LOAD_NEED: stat_d = rgt_pkg::ST_LOADED;
      rgt_pkg::CMD_LOAD_FREE: stat_d = rgt_pkg::ST_LOADED;
      default:                stat_d = rgt_pkg::ST_LOADED;
    endcase
  end
  assign grant_ok = (cmd_q == rgt_pkg::CMD_REQUEST) && !fail_q;

  // Capture word, cache check results, load result registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q    <= rgt_pkg::cmd_e'(req_data_i.command);
      row_q    <= rgt_pkg::row_of(req_data_i.process);
      res_q    <= req_data_i.resource;
      amount_q <= UB'(req_data_i.amount);
      for (int k = 0; k < NR; k++) begin
        credit_q[k] <= UB'(cred_in[k]);
      end
    end
    if (ctl_i.chk) begin
      held_c_q[ctl_i.idx] <= hd;
      rem_c_q[ctl_i.idx]  <= rem;
    end
    if (ctl_i.fin) begin
      rstat_q <= stat_d;
      for (int k = 0; k < rgt_pkg::CRED_N; k++) begin
        if (k < NR && grant_ok) begin
          rgnt_q[k] <= gnt_w_q[k];
        end else begin
          rgnt_q[k] <= '0;
        end
      end
    end
  end

  // Need and held memories with registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.do_load && res_ok && (cmd_q == rgt_pkg::CMD_LOAD_NEED)) begin
      need_mem[ld_addr] <= amount_q;
    end
    if (ctl_i.upd && (cmd_q == rgt_pkg::CMD_REQUEST)) begin
      held_mem[rd_addr] <= held_c_q[ctl_i.idx] + grant_g;
    end
    if (ctl_i.rd) begin
      need_rd_q <= need_mem[rd_addr];
      held_rd_q <= held_mem[rd_addr];
      need_rv_q <= need_vld_q[rd_addr];
      held_rv_q <= held_vld_q[rd_addr];
    end
  end

  // Free counts, entry valid bits, fail flag, working grants, type count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= rgt_pkg::CFG_RESET;
      fail_q     <= 1'b0;
      need_vld_q <= '0;
      held_vld_q <= '0;
      for (int k = 0; k < NR; k++) begin
        free_q[k]  <= '0;
        gnt_w_q[k] <= '0;
      end
    end else begin
      if (cfg_valid_i) count_q <= cfg_data_i;
      if (ctl_i.latch) begin
        fail_q <= 1'b0;
        for (int k = 0; k < NR; k++) begin
          gnt_w_q[k] <= '0;
        end
      end
      if (ctl_i.chk && fail_now) fail_q <= 1'b1;
      if (ctl_i.do_load && res_ok) begin
        unique case (cmd_q)
          rgt_pkg::CMD_LOAD_NEED: need_vld_q[ld_addr] <= 1'b1;
          rgt_pkg::CMD_LOAD_FREE: free_q[res_idx] <= amount_q;
          rgt_pkg::CMD_REQUEST:   ;
          rgt_pkg::CMD_RELEASE:   ;
          default:                ;
        endcase
      end
      if (ctl_i.upd) begin
        if (cmd_q == rgt_pkg::CMD_REQUEST) begin
          free_q[ctl_i.idx]  <= free_q[ctl_i.idx] - grant_g;
          gnt_w_q[ctl_i.idx] <= grant_g;
          held_vld_q[rd_addr] <= 1'b1;
        end else begin
          free_q[ctl_i.idx]   <= free_sat;
          held_vld_q[rd_addr] <= 1'b0;
        end
      end
    end
  end

  assign sts_o.cmd   = cmd_q;
  assign sts_o.n_act = n_act;
  assign sts_o.fail  = fail_q;

  assign rsp_data_o.status    = rstat_q;
  assign rsp_data_o.granted_0 = rgt_pkg::FIELD_W'(rgnt_q[0]);
  assign rsp_data_o.granted_1 = rgt_pkg::FIELD_W'(rgnt_q[1]);
  assign rsp_data_o.granted_2 = rgt_pkg::FIELD_W'(rgnt_q[2]);
  assign rsp_data_o.granted_3 = rgt_pkg::FIELD_W'(rgnt_q[3]);

endmodule

### tb/tb_resource_grant_table.sv
// Self-checking testbench for the resource grant table: directed and random words
module tb_resource_grant_table;
  import rgt_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int PLAN_ROWS   = 23;
  localparam int PHASES      = 6;

  // Directed word plus, where it is obvious, the status it must return
  typedef struct {
    cmd_e               op;
    logic [PROC_W-1:0]  proc_no;
    logic [RES_W-1:0]   res_no;
    logic [FIELD_W-1:0] amt;
    logic [31:0]        credits;  // {credit_3, credit_2, credit_1, credit_0}
    bit                 typed;
    status_e            st;
  } plan_row_t;

  typedef struct {
    bit   typed;
    rsp_t word;
  } fixed_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rgt_req_if req_if ();
  rgt_rsp_if rsp_if ();
  rgt_cfg_if cfg_if ();

  resource_grant_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Predictor state
  logic [UNIT_BITS-1:0] need_q [MAX_PROCS][MAX_RES];
  logic [UNIT_BITS-1:0] held_q [MAX_PROCS][MAX_RES];
  logic [UNIT_BITS-1:0] free_q [MAX_RES];
  logic [CFG_W-1:0]     act_count = CFG_RESET;

  rsp_t       outcome_q [$];
  fixed_out_t fixed_q [$];

  int errors     = 0;
  int cycles     = 0;
  int words_sent = 0;
  bit no_idle    = 1'b0;
  bit long_hold  = 1'b0;

  plan_row_t plan [PLAN_ROWS] = '{
    // after reset: nothing needed, nothing free
    '{CMD_REQUEST,   4'd0,  2'd0, 8'h00, 32'hFFFF_FFFF, 1'b1, ST_GRANTED},
    '{CMD_RELEASE,   4'd15, 2'd0, 8'h00, 32'h0000_0000, 1'b1, ST_RELEASED},
    '{CMD_LOAD_NEED, 4'd0,  2'd0, 8'hFF, 32'h0000_0000, 1'b1, ST_LOADED},
    '{CMD_REQUEST,   4'd0,  2'd0, 8'h00, 32'hFFFF_FFFF, 1'b1, ST_UNSAFE},
    '{CMD_LOAD_FREE, 4'd15, 2'd0, 8'hFF, 32'h0000_0000, 1'b1, ST_LOADED},
    // partial grant, then the rest
    '{CMD_REQUEST,   4'd0,  2'd1, 8'h33, 32'h0000_000F, 1'b0, ST_GRANTED},
    '{CMD_RELEASE,   4'd0,  2'd0, 8'h00, 32'h0000_0000, 1'b1, ST_NOT_FINISHED},
    '{CMD_REQUEST,   4'd0,  2'd2, 8'hCC, 32'hFFFF_FFFF, 1'b0, ST_GRANTED},
    // need reloaded below held
    '{CMD_LOAD_NEED, 4'd0,  2'd0, 8'h10, 32'h0000_0000, 1'b1, ST_LOADED},
    '{CMD_REQUEST,   4'd0,  2'd0, 8'h00, 32'hFFFF_FFFF, 1'b0, ST_GRANTED},
    '{CMD_RELEASE,   4'd0,  2'd0, 8'h00, 32'h0000_0000, 1'b1, ST_NOT_FINISHED},
    // release into a nearly full pool saturates
    '{CMD_LOAD_NEED, 4'd0,  2'd0, 8'hFF, 32'h0000_0000, 1'b1, ST_LOADED},
    '{CMD_LOAD_FREE, 4'd0,  2'd0, 8'hC8, 32'h0000_0000, 1'b1, ST_LOADED},
    '{CMD_RELEASE,   4'd0,  2'd0, 8'h00, 32'h0000_0000, 1'b1, ST_RELEASED},
    // top row, every type
    '{CMD_LOAD_NEED, 4'd15, 2'd3, 8'hAA, 32'h0000_0000, 1'b1, ST_LOADED},
    '{CMD_LOAD_NEED, 4'd15, 2'd1, 8'h55, 32'h0000_0000, 1'b1, ST_LOADED},
    '{CMD_LOAD_FREE, 4'd7,  2'd3, 8'hFF, 32'h0000_0000, 1'b1, ST_LOADED},
    '{CMD_LOAD_FREE, 4'd8,  2'd1, 8'h55, 32'h0000_0000, 1'b1, ST_LOADED},
    '{CMD_LOAD_FREE, 4'd9,  2'd2, 8'hAA, 32'h0000_0000, 1'b1, ST_LOADED},
    '{CMD_REQUEST,   4'd15, 2'd3, 8'hFF, 32'h8000_3000, 1'b0, ST_GRANTED},
    '{CMD_REQUEST,   4'd15, 2'd1, 8'h55, 32'hFFFF_FFFF, 1'b0, ST_GRANTED},
    '{CMD_RELEASE,   4'd15, 2'd0, 8'h00, 32'h0000_0000, 1'b0, ST_RELEASED},
    '{CMD_REQUEST,   4'd15, 2'd0, 8'h00, 32'h0000_0000, 1'b0, ST_GRANTED}
  };

  int phase_count [PHASES] = '{1, 0, 7, 2, 3, 4};
  int phase_words [PHASES] = '{80, 20, 90, 70, 80, 110};

  // Clock: period 10
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Give up after a generous number of cycles
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL resource_grant_table");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic logic [UNIT_BITS-1:0] remaining_units(int row, int t);
    return (need_q[row][t] > held_q[row][t]) ? need_q[row][t] - held_q[row][t] : '0;
  endfunction

  // Work out the response to one word and advance the tables
  function automatic rsp_t grant_outcome(req_t w);
    rsp_t                 o;
    logic [UNIT_BITS-1:0] g [MAX_RES];
    logic [UNIT_BITS-1:0] cred [CRED_N];
    logic [UNIT_BITS-1:0] left;
    logic [UNIT_BITS:0]   sum;
    int                   row;
    int                   n;
    int                   i;
    bit                   refuse;
    bit                   done;
    o = '0;
    row = int'(w.process) % MAX_PROCS;
    n = (int'(act_count) > MAX_RES) ? MAX_RES : int'(act_count);
    cred = '{w.credit_0, w.credit_1, w.credit_2, w.credit_3};
    for (i = 0; i < MAX_RES; i++) g[i] = '0;
    case (w.command)
      CMD_REQUEST: begin
        refuse = 1'b0;
        for (i = 0; i < n; i++) begin
          if (remaining_units(row, i) > free_q[i]) refuse = 1'b1;
        end
        if (refuse) begin
          o.status = ST_UNSAFE;
        end else begin
          for (i = 0; i < n; i++) begin
            left = remaining_units(row, i);
            g[i] = (cred[i] < left) ? cred[i] : left;
            held_q[row][i] = held_q[row][i] + g[i];
            free_q[i] = free_q[i] - g[i];
          end
          o.status = ST_GRANTED;
        end
      end
      CMD_RELEASE: begin
        done = 1'b1;
        for (i = 0; i < n; i++) begin
          if (need_q[row][i] != held_q[row][i]) done = 1'b0;
        end
        if (done) begin
          for (i = 0; i < n; i++) begin
            sum = {1'b0, free_q[i]} + {1'b0, held_q[row][i]};
            free_q[i] = sum[UNIT_BITS] ? '1 : sum[UNIT_BITS-1:0];
            held_q[row][i] = '0;
          end
          o.status = ST_RELEASED;
        end else begin
          o.status = ST_NOT_FINISHED;
        end
      end
      CMD_LOAD_NEED: begin
        if (int'(w.resource) < MAX_RES) need_q[row][w.resource] = w.amount;
        o.status = ST_LOADED;
      end
      default: begin
        if (int'(w.resource) < MAX_RES) free_q[w.resource] = w.amount;
        o.status = ST_LOADED;
      end
    endcase
    o.granted_0 = g[0];
    o.granted_1 = g[1];
    o.granted_2 = g[2];
    o.granted_3 = g[3];
    return o;
  endfunction

  // Track configuration, predict accepted words, check accepted responses
  always @(posedge clk_i) begin : monitor
    rsp_t               predicted;
    rsp_t               want;
    fixed_out_t         fixed;
    logic [FIELD_W-1:0] got_g [CRED_N];
    logic [FIELD_W-1:0] want_g [CRED_N];
    int                 i;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) act_count = cfg_if.resource_count;
      if (req_if.valid && req_if.ready) begin
        predicted = grant_outcome(req_if.data);
        if (fixed_q.size() != 0) begin
          fixed = fixed_q.pop_front();
          if (fixed.typed) predicted = fixed.word;
        end
        outcome_q.push_back(predicted);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("response word with nothing outstanding");
        end else begin
          want = outcome_q.pop_front();
          if (rsp_if.data.status !== want.status) begin
            report_mismatch($sformatf("status got %0d want %0d",
                                      rsp_if.data.status, want.status));
          end
          got_g = '{rsp_if.data.granted_0, rsp_if.data.granted_1,
                    rsp_if.data.granted_2, rsp_if.data.granted_3};
          want_g = '{want.granted_0, want.granted_1, want.granted_2, want.granted_3};
          for (i = 0; i < CRED_N; i++) begin
            if (got_g[i] !== want_g[i]) begin
              report_mismatch($sformatf("granted_%0d got %0d want %0d",
                                        i, got_g[i], want_g[i]));
            end
          end
        end
      end
    end
  end

  // Response side: random stalls, plus one long hold-off on request
  initial begin : rsp_side
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        stall = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  function automatic req_t rand_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return req_t'(r[$bits(req_t)-1:0]);
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(req_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    do @(posedge clk_i); while (!req_if.ready);
    words_sent++;
  endtask

  // Drop the request line, let the last word reach the predictor, wait for every response
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CFG_W-1:0] v);
    drain();
    cfg_if.valid          <= 1'b1;
    cfg_if.resource_count <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // One process: load its needs, maybe top up the pool, request, release
  task automatic run_job();
    logic [PROC_W-1:0] p;
    req_t              w;
    int                i;
    p = PROC_W'($urandom_range(0, MAX_PROCS - 1));
    for (i = 0; i < MAX_RES; i++) begin
      w = rand_word();
      w.command  = CMD_LOAD_NEED;
      w.process  = p;
      w.resource = RES_W'(i);
      w.amount   = FIELD_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 40));
      send_word(w);
    end
    if ($urandom_range(0, 1) == 0) begin
      w = rand_word();
      w.command = CMD_LOAD_FREE;
      w.amount  = FIELD_W'($urandom_range(20, 255));
      send_word(w);
    end
    repeat ($urandom_range(1, 4)) begin
      w = rand_word();
      w.command  = CMD_REQUEST;
      w.process  = p;
      w.credit_0 = ($urandom_range(0, 3) == 0) ? 8'hFF : FIELD_W'($urandom_range(0, 25));
      w.credit_1 = ($urandom_range(0, 3) == 0) ? 8'hFF : FIELD_W'($urandom_range(0, 25));
      w.credit_2 = ($urandom_range(0, 3) == 0) ? 8'hFF : FIELD_W'($urandom_range(0, 25));
      w.credit_3 = ($urandom_range(0, 3) == 0) ? 8'hFF : FIELD_W'($urandom_range(0, 25));
      send_word(w);
    end
    w = rand_word();
    w.command = CMD_RELEASE;
    w.process = p;
    send_word(w);
  endtask

  initial begin : stimulus
    req_t       w;
    fixed_out_t f;
    int         k;
    int         target;
    rst_ni                <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.data           <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.resource_count <= '0;
    for (k = 0; k < MAX_PROCS * MAX_RES; k++) begin
      need_q[k / MAX_RES][k % MAX_RES] = '0;
      held_q[k / MAX_RES][k % MAX_RES] = '0;
    end
    for (k = 0; k < MAX_RES; k++) free_q[k] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset setting
    foreach (plan[k]) begin
      w = '0;
      w.command  = plan[k].op;
      w.process  = plan[k].proc_no;
      w.resource = plan[k].res_no;
      w.amount   = plan[k].amt;
      {w.credit_3, w.credit_2, w.credit_1, w.credit_0} = plan[k].credits;
      f.typed = plan[k].typed;
      f.word  = '0;
      f.word.status = plan[k].st;
      fixed_q.push_back(f);
      send_word(w);
    end

    // Random phases, each under its own type count
    for (k = 0; k < PHASES; k++) begin
      write_count(CFG_W'(phase_count[k]));
      no_idle = (phase_count[k] == 3);
      if (phase_count[k] == 7) long_hold = 1'b1;
      target = words_sent + phase_words[k];
      while (words_sent < target) begin
        if ($urandom_range(0, 9) < 7) begin
          run_job();
        end else begin
          send_word(rand_word());
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS resource_grant_table");
    end else begin
      $display("FAIL resource_grant_table");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/rgt_pkg.sv
hdl/rgt_chan_if.sv
hdl/rgt_controller.sv
hdl/rgt_datapath.sv
hdl/resource_grant_table.sv
tb/tb_resource_grant_table.sv
